>>> rtl/core/lpfe_pkg.sv
// ============================================================================
// lpfe_pkg
// Shared types and constants for the LCD page frame buffer engine.
// ============================================================================
`default_nettype none

package lpfe_pkg;

    localparam int COLUMNS_DEF = 128;
    localparam int PAGES_DEF   = 4;

    // Operation codes carried on the slave tuser field
    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_FILL  = 2'd1;
    localparam logic [1:0] FUNC_BAR   = 2'd2;
    localparam logic [1:0] FUNC_SCAN  = 2'd3;

    // Refresh stream command bytes
    localparam logic [7:0] CMD_COL_LO   = 8'h00;
    localparam logic [7:0] CMD_COL_HI   = 8'h10;
    localparam logic [7:0] CMD_PAGE_SET = 8'hB0;

    localparam logic [7:0] BYTE_CLEAR = 8'h00;
    localparam logic [7:0] BYTE_FILL  = 8'hFF;

    localparam int BAR_WIDTH = 4;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_BAR,
        ST_SCAN
    } lpfe_state_t;

    // Frame store port controls
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } lpfe_store_ctl_t;

    // One scan result handed to the output register
    typedef struct packed {
        logic       load;
        logic [7:0] out_byte;
        logic       is_data;
        logic       frame_end;
    } lpfe_result_t;

endpackage

`default_nettype wire

>>> rtl/core/lpfe_store.sv
// ============================================================================
// lpfe_store
// Frame store memory: a write and a registered read that share one address.
// ============================================================================
`default_nettype none

module lpfe_store #(
    parameter int DEPTH = lpfe_pkg::PAGES_DEF * lpfe_pkg::COLUMNS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire                     clk,
    input  wire lpfe_pkg::lpfe_store_ctl_t ctl,
    input  wire  [AW-1:0]           addr,
    input  wire  [7:0]              wdata,
    output logic [7:0]              rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lpfe_ctrl.sv
// ============================================================================
// lpfe_ctrl
// Sequencer: sweeps the store for clear/fill/reset, writes bar columns one
// byte a cycle and walks the refresh stream position, all through one
// shared page/column address unit.
// ============================================================================
`default_nettype none

module lpfe_ctrl #(
    parameter int COLUMNS = lpfe_pkg::COLUMNS_DEF,
    parameter int PAGES   = lpfe_pkg::PAGES_DEF,
    parameter int AW      = $clog2(PAGES * COLUMNS)
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         s_valid,
    output logic                        s_ready,
    input  wire  [1:0]                  func,
    input  wire  [7:0]                  bar_column,
    input  wire  [7:0]                  bar_height,
    input  wire                         out_free,
    output lpfe_pkg::lpfe_result_t      result,
    output lpfe_pkg::lpfe_store_ctl_t   store_ctl,
    output logic [AW-1:0]               store_addr,
    output logic [7:0]                  store_wdata,
    input  wire  [7:0]                  store_rdata
);

    localparam int PW          = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int CW          = $clog2(COLUMNS);
    localparam int OW          = $clog2(COLUMNS + 3);
    localparam int HTW         = $clog2(PAGES * 8 + 1);
    localparam int BAR_COL_MAX = COLUMNS - lpfe_pkg::BAR_WIDTH;
    localparam int BAR_H_MAX   = PAGES * 8;

    lpfe_pkg::lpfe_state_t state_reg, state_next;
    logic [PW-1:0]  pg_reg, pg_next;
    logic [CW-1:0]  col_reg, col_next;
    logic [7:0]     fill_reg, fill_next;
    logic [CW-1:0]  bar_col_reg, bar_col_next;
    logic [HTW-1:0] bar_hgt_reg, bar_hgt_next;
    logic [PW-1:0]  scan_pg_reg, scan_pg_next;
    logic [OW-1:0]  scan_off_reg, scan_off_next;
    logic           sdata_reg, sdata_next;
    logic           slast_reg, slast_next;
    logic [7:0]     scmd_reg, scmd_next;

    logic           accept;
    logic [CW-1:0]  col_clamp;
    logic [HTW-1:0] hgt_clamp;
    logic [7:0]     bar_bits;
    logic [7:0]     base8;
    logic [7:0]     hgt8;
    logic [2:0]     lit_rows;
    logic [PW-1:0]  addr_pg;
    logic [CW-1:0]  addr_col;
    logic [AW:0]    addr_full;
    logic           page_done;
    logic           col_done;
    logic           scan_off_last;

    assign accept = s_valid && s_ready;

    assign col_clamp = ({1'b0, bar_column} > 9'(BAR_COL_MAX)) ? CW'(BAR_COL_MAX)
                                                              : CW'(bar_column);
    assign hgt_clamp = (bar_height > 8'(BAR_H_MAX)) ? HTW'(BAR_H_MAX) : HTW'(bar_height);

    // Pixel bits of one page of a bar column; bit 7 is the lowest row
    always_comb
    begin
        base8    = (8'(PAGES - 1) - 8'(pg_reg)) << 3;
        hgt8     = 8'(bar_hgt_reg);
        lit_rows = 3'(hgt8 - base8);
        if (hgt8 >= base8 + 8'd8)
        begin
            bar_bits = 8'hFF;
        end
        else if (hgt8 <= base8)
        begin
            bar_bits = 8'h00;
        end
        else
        begin
            bar_bits = ~(8'hFF >> lit_rows);
        end
    end

    // Shared address unit: page * COLUMNS + column
    always_comb
    begin
        if (state_reg == lpfe_pkg::ST_IDLE)
        begin
            addr_pg  = scan_pg_reg;
            addr_col = CW'(scan_off_reg - OW'(3));
        end
        else
        begin
            addr_pg  = pg_reg;
            addr_col = col_reg;
        end
        addr_full  = (AW + 1)'(addr_pg) * (AW + 1)'(COLUMNS) + (AW + 1)'(addr_col);
        store_addr = addr_full[AW-1:0];
    end

    assign page_done     = (pg_reg == PW'(PAGES - 1));
    assign col_done      = (col_reg == CW'(COLUMNS - 1));
    assign scan_off_last = (scan_off_reg == OW'(COLUMNS + 2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lpfe_pkg::ST_SWEEP;
            pg_reg       <= '0;
            col_reg      <= '0;
            fill_reg     <= lpfe_pkg::BYTE_CLEAR;
            scan_pg_reg  <= '0;
            scan_off_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pg_reg       <= pg_next;
            col_reg      <= col_next;
            fill_reg     <= fill_next;
            scan_pg_reg  <= scan_pg_next;
            scan_off_reg <= scan_off_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bar_col_reg <= bar_col_next;
        bar_hgt_reg <= bar_hgt_next;
        sdata_reg   <= sdata_next;
        slast_reg   <= slast_next;
        scmd_reg    <= scmd_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        pg_next       = pg_reg;
        col_next      = col_reg;
        fill_next     = fill_reg;
        bar_col_next  = bar_col_reg;
        bar_hgt_next  = bar_hgt_reg;
        scan_pg_next  = scan_pg_reg;
        scan_off_next = scan_off_reg;
        sdata_next    = sdata_reg;
        slast_next    = slast_reg;
        scmd_next     = scmd_reg;
        s_ready       = 1'b0;
        store_ctl     = '0;
        store_wdata   = fill_reg;
        result.load      = 1'b0;
        result.out_byte  = sdata_reg ? store_rdata : scmd_reg;
        result.is_data   = sdata_reg;
        result.frame_end = slast_reg;

        case (state_reg)
            lpfe_pkg::ST_SWEEP:
            begin
                store_ctl.wr_en = 1'b1;
                if (col_done)
                begin
                    col_next = '0;
                    pg_next  = page_done ? '0 : pg_reg + PW'(1);
                    if (page_done)
                    begin
                        state_next = lpfe_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
            end

            lpfe_pkg::ST_IDLE:
            begin
                s_ready = 1'b1;
                if (accept)
                begin
                    case (func)
                        lpfe_pkg::FUNC_CLEAR,
                        lpfe_pkg::FUNC_FILL:
                        begin
                            fill_next  = (func == lpfe_pkg::FUNC_FILL) ? lpfe_pkg::BYTE_FILL
                                                                       : lpfe_pkg::BYTE_CLEAR;
                            pg_next    = '0;
                            col_next   = '0;
                            state_next = lpfe_pkg::ST_SWEEP;
                        end
                        lpfe_pkg::FUNC_BAR:
                        begin
                            bar_col_next = col_clamp;
                            bar_hgt_next = hgt_clamp;
                            pg_next      = '0;
                            col_next     = col_clamp;
                            state_next   = lpfe_pkg::ST_BAR;
                        end
                        default:
                        begin
                            // Scan: issue the store read for a data byte and advance the stream
                            sdata_next = 1'b0;
                            slast_next = (scan_pg_reg == PW'(PAGES - 1)) && scan_off_last;
                            case (scan_off_reg)
                                OW'(0):  scmd_next = lpfe_pkg::CMD_COL_LO;
                                OW'(1):  scmd_next = lpfe_pkg::CMD_COL_HI;
                                OW'(2):  scmd_next = lpfe_pkg::CMD_PAGE_SET
                                                     | 8'(scan_pg_reg);
                                default:
                                begin
                                    scmd_next       = lpfe_pkg::CMD_COL_LO;
                                    sdata_next      = 1'b1;
                                    store_ctl.rd_en = 1'b1;
                                end
                            endcase
                            if (scan_off_last)
                            begin
                                scan_off_next = '0;
                                scan_pg_next  = (scan_pg_reg == PW'(PAGES - 1))
                                                ? '0 : scan_pg_reg + PW'(1);
                            end
                            else
                            begin
                                scan_off_next = scan_off_reg + OW'(1);
                            end
                            state_next = lpfe_pkg::ST_SCAN;
                        end
                    endcase
                end
            end

            lpfe_pkg::ST_BAR:
            begin
                store_ctl.wr_en = 1'b1;
                store_wdata     = bar_bits;
                if (page_done)
                begin
                    pg_next = '0;
                    if (col_reg == bar_col_reg + CW'(lpfe_pkg::BAR_WIDTH - 1))
                    begin
                        state_next = lpfe_pkg::ST_IDLE;
                    end
                    else
                    begin
                        col_next = col_reg + CW'(1);
                    end
                end
                else
                begin
                    pg_next = pg_reg + PW'(1);
                end
            end

            lpfe_pkg::ST_SCAN:
            begin
                // Hold until the output slot can take the byte
                if (out_free)
                begin
                    result.load = 1'b1;
                    state_next  = lpfe_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lpfe_pkg::ST_IDLE;
            end
        endcase
    end

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(store_ctl.wr_en && store_ctl.rd_en))
        else $error("store write and read issued together");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        result.load |-> out_free)
        else $error("result loaded into a full output slot");

    a_scan_next: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func == lpfe_pkg::FUNC_SCAN) |=> state_reg == lpfe_pkg::ST_SCAN)
        else $error("scan transaction did not enter output state");

    a_last_data: assert property (@(posedge clk) disable iff (!rst_n)
        (result.load && result.frame_end) |-> result.is_data)
        else $error("frame end marked on a command byte");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpfe_pkg::ST_SWEEP || state_reg == lpfe_pkg::ST_BAR) |-> !accept)
        else $error("transaction accepted while store busy");

endmodule

`default_nettype wire

>>> rtl/core/lcd_page_framebuffer_engine_top.sv
// ============================================================================
// lcd_page_framebuffer_engine_top
// Monochrome page frame store with clear, fill, bar drawing and a refresh
// byte stream, with a registered master-side output slot.
// ============================================================================
// Scan: the store read is registered; the byte is loaded into the output slot
//   once the slot is free, and no new request is taken until then.
// Clear/fill: sweeps the whole store, one store byte a cycle.
// Draw bar: every page of each bar column, one page byte of a column a cycle.
// Reset: clears control state, then sweeps zeros through the whole store
//   with s_tready low.
`default_nettype none

module lcd_page_framebuffer_engine_top #(
    parameter int COLUMNS = lpfe_pkg::COLUMNS_DEF,
    parameter int PAGES   = lpfe_pkg::PAGES_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,    // [7:0] bar_column, [15:8] bar_height
    input  wire  [1:0]  s_tuser,    // [1:0] func
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tuser,    // [0] is_data
    output logic        m_tlast
);

    localparam int DEPTH = PAGES * COLUMNS;
    localparam int AW    = $clog2(DEPTH);

    lpfe_pkg::lpfe_result_t    result;
    lpfe_pkg::lpfe_store_ctl_t store_ctl;
    logic [AW-1:0] store_addr;
    logic [7:0]    store_wdata;
    logic [7:0]    store_rdata;
    logic          out_free;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_byte_reg;
    logic       m_data_reg;
    logic       m_last_reg;

    lpfe_ctrl #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES),
        .AW      (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .func        (s_tuser),
        .bar_column  (s_tdata[7:0]),
        .bar_height  (s_tdata[15:8]),
        .out_free    (out_free),
        .result      (result),
        .store_ctl   (store_ctl),
        .store_addr  (store_addr),
        .store_wdata (store_wdata),
        .store_rdata (store_rdata)
    );

    lpfe_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .ctl   (store_ctl),
        .addr  (store_addr),
        .wdata (store_wdata),
        .rdata (store_rdata)
    );

    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (result.load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.load)
        begin
            m_byte_reg <= result.out_byte;
            m_data_reg <= result.is_data;
            m_last_reg <= result.frame_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

>>> dv/tb.sv
// ============================================================================
// tb
// Self-checking bench for the LCD page frame buffer engine. A queue of
// operations (clear, fill, bar, scan) is driven on the slave stream. A local
// frame store model predicts each refresh byte, and the monitor compares it
// with the master stream, under random idling on both sides.
// ============================================================================
`default_nettype none

module tb;

    localparam int COLS       = 128;
    localparam int PGS        = 4;
    localparam int STORE_SZ   = COLS * PGS;
    localparam int PAGE_LEN   = COLS + 3;
    localparam int FRAME_LEN  = PGS * PAGE_LEN;
    localparam int COL_MAX    = COLS - lpfe_pkg::BAR_WIDTH;
    localparam int HGT_MAX    = PGS * 8;
    localparam int N_RANDOM   = 1280;
    localparam int TAIL_ITEMS = 150;
    localparam int SETTLE     = 2 * STORE_SZ + 100;
    localparam int STUCK_MAX  = 6000;

    typedef struct {
        logic [1:0] func;
        logic [7:0] column;
        logic [7:0] height;
        bit         drain_first;
    } fb_op_t;

    typedef struct {
        logic [7:0] value;
        logic       is_data;
        logic       frame_end;
    } scan_byte_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    lcd_page_framebuffer_engine_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] bar_column, [15:8] bar_height
        .s_tuser  (s_tuser),    // [1:0] func
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [7:0] out_byte
        .m_tuser  (m_tuser),    // [0] is_data
        .m_tlast  (m_tlast)
    );

    fb_op_t     pending_ops[$];
    scan_byte_t expected_bytes[$];
    fb_op_t     op_on_bus;

    logic [7:0]  shadow_store [STORE_SZ];
    int unsigned refresh_pos;

    int unsigned ops_accepted;
    int unsigned bytes_checked;
    int unsigned frames_seen;
    int unsigned op_count [4];
    int unsigned fail_count;
    int unsigned stuck_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("MISMATCH: %s", msg);
    endtask

    // Apply one accepted operation to the shadow store; scans queue a byte.
    function automatic void track_frame_op(input fb_op_t op);
        int unsigned col;
        int unsigned hgt;
        int unsigned pg;
        int unsigned off;
        logic [7:0]  bits;
        scan_byte_t  sb;
        case (op.func)
            lpfe_pkg::FUNC_CLEAR:
                for (int i = 0; i < STORE_SZ; i++) shadow_store[i] = lpfe_pkg::BYTE_CLEAR;
            lpfe_pkg::FUNC_FILL:
                for (int i = 0; i < STORE_SZ; i++) shadow_store[i] = lpfe_pkg::BYTE_FILL;
            lpfe_pkg::FUNC_BAR:
            begin
                col = (op.column > COL_MAX) ? COL_MAX : op.column;
                hgt = (op.height > HGT_MAX) ? HGT_MAX : op.height;
                for (int c = col; c < col + lpfe_pkg::BAR_WIDTH; c++)
                begin
                    for (int p = 0; p < PGS; p++)
                    begin
                        // page 0 is the top; bit 7 is the lowest row of a page
                        bits = '0;
                        for (int r = 0; r < 8; r++)
                            if ((PGS - 1 - p) * 8 + r < hgt)
                                bits[7 - r] = 1'b1;
                        shadow_store[p * COLS + c] = bits;
                    end
                end
            end
            default:
            begin
                pg  = refresh_pos / PAGE_LEN;
                off = refresh_pos % PAGE_LEN;
                sb.is_data = 1'b0;
                if (off == 0)
                    sb.value = lpfe_pkg::CMD_COL_LO;
                else if (off == 1)
                    sb.value = lpfe_pkg::CMD_COL_HI;
                else if (off == 2)
                    sb.value = lpfe_pkg::CMD_PAGE_SET | 8'(pg);
                else
                begin
                    sb.value   = shadow_store[pg * COLS + off - 3];
                    sb.is_data = 1'b1;
                end
                sb.frame_end = (refresh_pos == FRAME_LEN - 1);
                refresh_pos  = (refresh_pos + 1 >= FRAME_LEN) ? 0 : refresh_pos + 1;
                expected_bytes.push_back(sb);
            end
        endcase
    endfunction

    function automatic fb_op_t make_op(input logic [1:0] f, input int c, input int h);
        fb_op_t op;
        op.func        = f;
        op.column      = 8'(c);
        op.height      = 8'(h);
        op.drain_first = 1'b0;
        return op;
    endfunction

    // Stimulus and end of run
    initial
    begin : stim
        fb_op_t op;
        int     run_len;
        int     pick;
        rst_n = 1'b0;
        refresh_pos   = 0;
        ops_accepted  = 0;
        bytes_checked = 0;
        frames_seen   = 0;
        fail_count    = 0;
        for (int i = 0; i < 4; i++) op_count[i] = 0;
        for (int i = 0; i < STORE_SZ; i++) shadow_store[i] = lpfe_pkg::BYTE_CLEAR;

        // directed: reset contents, commands, clamps and bar heights
        for (int i = 0; i < 5; i++) pending_ops.push_back(make_op(lpfe_pkg::FUNC_SCAN, 0, 0));
        pending_ops.push_back(make_op(lpfe_pkg::FUNC_FILL, 255, 255));
        pending_ops.push_back(make_op(lpfe_pkg::FUNC_SCAN, 255, 255));
        pending_ops.push_back(make_op(lpfe_pkg::FUNC_BAR, 0, 0));
        pending_ops.push_back(make_op(lpfe_pkg::FUNC_BAR, 255, 255));
        pending_ops.push_back(make_op(lpfe_pkg::FUNC_BAR, 124, 32));
        pending_ops.push_back(make_op(lpfe_pkg::FUNC_BAR, 125, 33));
        pending_ops.push_back(make_op(lpfe_pkg::FUNC_BAR, 4, 1));
        pending_ops.push_back(make_op(lpfe_pkg::FUNC_BAR, 8, 8));
        pending_ops.push_back(make_op(lpfe_pkg::FUNC_BAR, 12, 9));
        pending_ops.push_back(make_op(lpfe_pkg::FUNC_BAR, 16, 31));
        for (int i = 0; i < 6; i++) pending_ops.push_back(make_op(lpfe_pkg::FUNC_SCAN, 0, 0));
        op = make_op(lpfe_pkg::FUNC_CLEAR, 170, 85);
        op.drain_first = 1'b1;
        pending_ops.push_back(op);
        pending_ops.push_back(make_op(lpfe_pkg::FUNC_SCAN, 85, 170));

        // random: runs of scans broken by store operations
        while (pending_ops.size() < N_RANDOM + 20)
        begin
            run_len = $urandom_range(1, 40);
            for (int i = 0; i < run_len; i++)
                pending_ops.push_back(make_op(lpfe_pkg::FUNC_SCAN, $urandom_range(0, 255),
                                              $urandom_range(0, 255)));
            pick = $urandom_range(0, 9);
            if (pick == 0)
                op = make_op(lpfe_pkg::FUNC_CLEAR, $urandom_range(0, 255),
                             $urandom_range(0, 255));
            else if (pick == 1)
                op = make_op(lpfe_pkg::FUNC_FILL, $urandom_range(0, 255),
                             $urandom_range(0, 255));
            else
                op = make_op(lpfe_pkg::FUNC_BAR,
                             ($urandom_range(0, 3) == 0) ? $urandom_range(118, 255)
                                                         : $urandom_range(0, 255),
                             ($urandom_range(0, 2) == 0) ? $urandom_range(0, 40)
                                                         : $urandom_range(0, 255));
            pending_ops.push_back(op);
        end
        pending_ops[400].drain_first = 1'b1;
        pending_ops[800].drain_first = 1'b1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || s_tvalid || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        while (expected_bytes.size() != 0)
        begin
            void'(expected_bytes.pop_front());
            note_failure("expected byte never arrived");
        end

        $display("Covered %0d ops (clear %0d, fill %0d, bar %0d, scan %0d).",
                 ops_accepted, op_count[lpfe_pkg::FUNC_CLEAR], op_count[lpfe_pkg::FUNC_FILL],
                 op_count[lpfe_pkg::FUNC_BAR], op_count[lpfe_pkg::FUNC_SCAN]);
        $display("Checked %0d refresh bytes over %0d full frames, %0d failures.",
                 bytes_checked, frames_seen, fail_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Slave-side driver
    always @(posedge clk or negedge rst_n)
    begin : drive
        int unsigned gap;
        bit          tail;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= lpfe_pkg::FUNC_CLEAR;
            gap = 0;
        end
        else
        begin
            tail = (pending_ops.size() < TAIL_ITEMS);
            if (s_tvalid && s_tready)
            begin
                track_frame_op(op_on_bus);
                op_count[op_on_bus.func]++;
                ops_accepted++;
            end
            if (s_tvalid && !s_tready)
            begin
                // hold the current transaction
            end
            else if (gap != 0 && !tail)
            begin
                gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_ops.size() == 0 ||
                     (pending_ops[0].drain_first && expected_bytes.size() != 0))
                s_tvalid <= 1'b0;
            else
            begin
                op_on_bus = pending_ops.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {op_on_bus.height, op_on_bus.column};
                s_tuser  <= op_on_bus.func;
                gap = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 9) : 0;
            end
        end
    end

    // Master-side ready: short random stalls plus two long hold-offs
    always @(posedge clk or negedge rst_n)
    begin : recv
        int unsigned stall;
        int unsigned next_hold_at;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall = 0;
            next_hold_at = 250;
        end
        else if (stall != 0)
        begin
            stall--;
            m_tready <= 1'b0;
        end
        else if (next_hold_at != 0 && ops_accepted >= next_hold_at)
        begin
            stall = $urandom_range(100, 160);
            next_hold_at = (next_hold_at < 900) ? 900 : 0;
            m_tready <= 1'b0;
        end
        else if (pending_ops.size() >= TAIL_ITEMS && $urandom_range(0, 7) == 0)
        begin
            stall = $urandom_range(0, 8);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Monitor and watchdog
    always @(posedge clk)
    begin : mon
        scan_byte_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_bytes.size() == 0)
                    note_failure($sformatf("unexpected byte %02h is_data %0b last %0b",
                                           m_tdata, m_tuser, m_tlast));
                else
                begin
                    want = expected_bytes.pop_front();
                    bytes_checked++;
                    if (m_tdata !== want.value)
                        note_failure($sformatf("byte %0d: out_byte exp %02h got %02h",
                                               bytes_checked, want.value, m_tdata));
                    if (m_tuser !== want.is_data)
                        note_failure($sformatf("byte %0d: is_data exp %0b got %0b",
                                               bytes_checked, want.is_data, m_tuser));
                    if (m_tlast !== want.frame_end)
                        note_failure($sformatf("byte %0d: frame_end exp %0b got %0b",
                                               bytes_checked, want.frame_end, m_tlast));
                    if (want.frame_end)
                        frames_seen++;
                end
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_MAX)
            begin
                $display("Watchdog: no transaction for %0d cycles", stuck_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
        else
            stuck_cycles = 0;
    end

endmodule

`default_nettype wire

>>> sim.f
rtl/core/lpfe_pkg.sv
rtl/core/lpfe_store.sv
rtl/core/lpfe_ctrl.sv
rtl/core/lcd_page_framebuffer_engine_top.sv
dv/tb.sv
